// ===== hdl/sm3_pkg.sv =====
// ----------------------------------------------------------------------------
// sm3_pkg
// shared types, constants and round functions of the sm3 hash engine
// ----------------------------------------------------------------------------
package sm3_pkg;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       msg_end;
    } t_in_word;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_word;

    // front-to-back queue entry: a byte to place, or an end command
    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_END  = 2'd1
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data;
    } t_q_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_FOLD,
        ST_OUT
    } t_state;

    localparam logic [31:0] T_LOW  = 32'h79CC4519;
    localparam logic [31:0] T_HIGH = 32'h7A879D8A;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam int          Q_DEPTH = 4;
    localparam int          Q_AW = 2;

    localparam logic [255:0] SM3_IV = {
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] p0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] p1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

// ===== hdl/sm3_front.sv =====
// ----------------------------------------------------------------------------
// sm3_front
// classifies input words and queues byte and end commands for the core
// ----------------------------------------------------------------------------
module sm3_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  sm3_pkg::t_in_word i_data,
    output logic              o_q_valid,
    input  logic              i_q_pop,
    output sm3_pkg::t_q_word  o_q_data
);
    import sm3_pkg::*;

    t_q_word          r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wp, r_rp;
    logic [Q_AW:0]    r_cnt, n_cnt;
    logic             r_half;      // byte pushed, end still pending
    logic             need2, push, done;
    t_q_word          w_entry;

    assign need2   = i_data.byte_present && i_data.msg_end && !r_half;
    assign push    = i_valid && (i_data.byte_present || i_data.msg_end)
                     && (r_cnt != (Q_AW+1)'(Q_DEPTH));
    assign done    = push && !need2;
    assign o_stall = i_valid && !done && (i_data.byte_present || i_data.msg_end);
    assign w_entry = (i_data.byte_present && !r_half)
                     ? '{cmd: CMD_BYTE, data: i_data.msg_byte}
                     : '{cmd: CMD_END, data: 8'd0};

    assign o_q_valid = (r_cnt != '0);
    assign o_q_data  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt + (Q_AW+1)'(push) - (Q_AW+1)'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= w_entry;
        end
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
            r_half <= 1'b0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_q_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= n_cnt;
            if (push) r_half <= need2;
        end
    end
endmodule

// ===== hdl/sm3_core.sv =====
// ----------------------------------------------------------------------------
// sm3_core
// packs bytes, pads, runs 64 rounds one per cycle and emits the digest
// ----------------------------------------------------------------------------
module sm3_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_q_pop,
    input  sm3_pkg::t_q_word   i_q_data,
    output logic               o_valid,
    input  logic               i_stall,
    output sm3_pkg::t_out_word o_data
);
    import sm3_pkg::*;

    t_state       r_state, n_state;
    logic [31:0]  r_w [16];       // sliding expansion window
    logic [31:0]  r_v [8];        // chaining value
    logic [31:0]  r_r [8];        // round registers a..h
    logic [63:0]  r_len, r_flen;
    logic [5:0]   r_pos;
    logic [5:0]   r_rnd;
    logic [2:0]   r_oi;
    logic         r_padding;      // compression belongs to padding
    logic         r_more;         // 0x80 landed too late, one more pad block
    logic         w_put, w_full;
    logic [7:0]   w_byte;
    logic [31:0]  w_new, a12, ss1, ss2, ff, gg, tt1, tt2, tj, wn;

    // byte to place: the queued byte while idle; in padding 0x80, zeros, then the length
    always_comb begin
        w_byte = 8'd0;
        if (r_state == ST_IDLE) begin
            w_byte = i_q_data.data;
        end else if (!r_padding) begin
            w_byte = PAD_BYTE;
        end else if (!r_more && r_pos >= 6'd56) begin
            w_byte = r_flen[8'(7 - r_pos[2:0]) * 8 +: 8];
        end
    end

    assign w_put  = (r_state == ST_IDLE && i_q_valid && i_q_data.cmd == CMD_BYTE)
                    || r_state == ST_PAD;
    assign w_full = w_put && (r_pos == 6'd63);
    assign o_q_pop = r_state == ST_IDLE && i_q_valid;

    // round datapath
    assign tj  = (r_rnd < 6'd16) ? T_LOW : T_HIGH;
    assign a12 = rotl(r_r[0], 5'd12);
    assign ss1 = rotl(a12 + r_r[4] + rotl(tj, r_rnd[4:0]), 5'd7);
    assign ss2 = ss1 ^ a12;
    assign ff  = (r_rnd < 6'd16) ? (r_r[0] ^ r_r[1] ^ r_r[2])
               : ((r_r[0] & r_r[1]) | (r_r[0] & r_r[2]) | (r_r[1] & r_r[2]));
    assign gg  = (r_rnd < 6'd16) ? (r_r[4] ^ r_r[5] ^ r_r[6])
               : ((r_r[4] & r_r[5]) | (~r_r[4] & r_r[6]));
    assign tt1 = ff + r_r[3] + ss2 + (r_w[0] ^ r_w[4]);
    assign tt2 = gg + r_r[7] + ss1 + r_w[0];
    assign wn  = p1(r_w[0] ^ r_w[7] ^ rotl(r_w[13], 5'd15))
                 ^ rotl(r_w[3], 5'd7) ^ r_w[10];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid && i_q_data.cmd == CMD_END) n_state = ST_PAD;
                else if (w_full) n_state = ST_COMP;
            end
            ST_PAD:  if (w_full) n_state = ST_COMP;
            ST_COMP: if (r_rnd == 6'd63) n_state = ST_FOLD;
            ST_FOLD: n_state = (!r_padding) ? ST_IDLE
                               : (r_more ? ST_PAD : ST_OUT);
            ST_OUT:  if (!i_stall && r_oi == 3'd7) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign w_new = {r_w[15][23:0], w_byte};

    always_comb begin
        o_valid = (r_state == ST_OUT);
        o_data.digest_word = r_v[r_oi];
        o_data.word_index  = r_oi;
        o_data.last_word   = (r_oi == 3'd7);
    end

    always_ff @(posedge i_clk) begin
        if (w_put) begin
            r_w[15] <= w_new;
            // a new word starts: retire the finished one into the window
            if (r_pos[1:0] == 2'd0) begin
                for (int k = 0; k < 15; k++) r_w[k] <= r_w[k+1];
            end
        end
        if (r_state == ST_COMP) begin
            for (int k = 0; k < 15; k++) r_w[k] <= r_w[k+1];
            r_w[15] <= wn;
            r_r[3] <= r_r[2]; r_r[2] <= rotl(r_r[1], 5'd9);
            r_r[1] <= r_r[0]; r_r[0] <= tt1;
            r_r[7] <= r_r[6]; r_r[6] <= rotl(r_r[5], 5'd19);
            r_r[5] <= r_r[4]; r_r[4] <= p0(tt2);
        end
        if (w_full) begin
            for (int k = 0; k < 8; k++) r_r[k] <= r_v[k];
        end
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pos     <= '0;
            r_rnd     <= '0;
            r_oi      <= '0;
            r_len     <= '0;
            r_flen    <= '0;
            r_padding <= 1'b0;
            r_more    <= 1'b0;
            for (int k = 0; k < 8; k++) r_v[k] <= SM3_IV[255-32*k -: 32];
        end else begin
            r_state <= n_state;
            if (w_put) r_pos <= r_pos + 6'd1;
            if (r_state == ST_IDLE && i_q_valid) begin
                if (i_q_data.cmd == CMD_BYTE) begin
                    r_len <= r_len + 64'd8;
                end else begin
                    r_flen    <= r_len;
                    r_padding <= 1'b0;
                end
            end
            // after the 0x80 byte, pad bytes are zero up to the length field
            if (r_state == ST_PAD) begin
                r_padding <= 1'b1;
                if (!r_padding) r_more <= (r_pos >= 6'd56);
            end
            if (r_state == ST_COMP) r_rnd <= r_rnd + 6'd1;
            if (r_state == ST_FOLD) begin
                r_more <= 1'b0;
                for (int k = 0; k < 8; k++) r_v[k] <= r_v[k] ^ r_r[k];
            end
            if (r_state == ST_OUT && !i_stall) begin
                r_oi <= r_oi + 3'd1;
                if (r_oi == 3'd7) begin
                    r_len <= '0;
                    r_padding <= 1'b0;
                    for (int k = 0; k < 8; k++) r_v[k] <= SM3_IV[255-32*k -: 32];
                end
            end
        end
    end
endmodule

// ===== hdl/sm3_hash_engine_unit.sv =====
// ----------------------------------------------------------------------------
// sm3_hash_engine_unit
// byte-stream sm3 hash with 256-bit digest delivered as eight 32-bit words
// ----------------------------------------------------------------------------
// usage
//   input channel: one word per accepted cycle, carrying a message byte
//   (byte_present), an end mark (msg_end), or both; a word with neither
//   is accepted and ignored
//   a front stage queues byte and end commands into a four-entry queue,
//   a word with both byte and end needs two queue slots and stalls until both are queued
//   the back core packs one byte per cycle while idle and the queue is not
//   empty; the 64th byte of a block starts 64 rounds at one round per cycle
//   in the single shared round unit, then a fold into the chaining value
//   at message end the core pads (up to 72 bytes, one per cycle in ST_PAD),
//   compresses one or two blocks, then shows eight digest words, index 0 first
//   output channel: o_valid holds each word until taken; while the receiver
//   stalls, the core and later the queue fill and the input stalls
//   reset loads the initial vector, clears length, position and queue
// ----------------------------------------------------------------------------
module sm3_hash_engine_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  sm3_pkg::t_in_word   i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output sm3_pkg::t_out_word  o_data
);
    import sm3_pkg::*;

    logic    q_valid, q_pop;
    t_q_word q_data;

    // front: classify and queue
    sm3_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_data(q_data)
    );

    // back: pack, pad, compress, emit
    sm3_core u_core (
        .i_clk, .i_rst_n,
        .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_data(q_data),
        .o_valid, .i_stall, .o_data
    );
endmodule

// ===== hdl/sm3_checker.sv =====
// ----------------------------------------------------------------------------
// sm3_checker
// port-level checks of the digest channel
// ----------------------------------------------------------------------------
module sm3_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input sm3_pkg::t_out_word o_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data)) else $error("stalled word changed");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.last_word == (o_data.word_index == 3'd7)))
        else $error("last flag mismatch");
    a_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_data.last_word |=> o_valid &&
        o_data.word_index == $past(o_data.word_index) + 3'd1)
        else $error("digest words not consecutive");
endmodule

bind sm3_hash_engine_unit sm3_checker u_sm3_checker (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_data
);
